/* design/lru_key_value_cache_core_macros.svh */
// assertion macros for the lru key-value cache core
// used by the files that carry concurrent checks; expects clk and arst_n in scope
`ifndef LRU_KEY_VALUE_CACHE_CORE_MACROS_SVH
`define LRU_KEY_VALUE_CACHE_CORE_MACROS_SVH
`ifndef NO_ASSERTIONS
// condition holds at every edge outside reset
`define LCC_ASSERT_ALWAYS(label, cond) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond)) \
		else $error("lcc check failed");
// antecedent implies consequent in the same cycle
`define LCC_ASSERT_IMPLY(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("lcc check failed");
// antecedent implies consequent in the next cycle
`define LCC_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("lcc check failed");
`else
`define LCC_ASSERT_ALWAYS(label, cond)
`define LCC_ASSERT_IMPLY(label, ante, cons)
`define LCC_ASSERT_NEXT(label, ante, cons)
`endif
`endif

/* design/lcc_pkg.sv */
// shared types and constants of the lru key-value cache core
// no dependencies
`timescale 1ns / 1ps
package lcc_pkg;
	localparam int KEY_W       = 16;
	localparam int VALUE_W     = 32;
	localparam int CAP_W       = 5;
	localparam int PDATA_W     = 32;
	localparam int ADDR_W      = 3;
	localparam int QUEUE_DEPTH = 2;

	// opcodes of the request channel
	localparam logic OP_GET = 1'b0;
	localparam logic OP_PUT = 1'b1;

	// register index as decoded from paddr[2]
	localparam logic REG_CAPACITY = 1'b0;

	localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

	// request as classified by the front end
	typedef struct packed {
		logic               is_put;
		logic [KEY_W-1:0]   key;
		logic [VALUE_W-1:0] value;
	} req_t;

	// capacity update toward the engine
	typedef struct packed {
		logic             wr;
		logic [CAP_W-1:0] cap;
	} cfg_t;
endpackage

/* design/lru_key_value_cache_core.sv */
// top level of the lru key-value cache: apb capacity register, front end and engine
// depends on lcc_pkg, lcc_front and lcc_engine
//
// channel  | signals                                   | role
// ---------+-------------------------------------------+-------------------------
// request  | in_valid/in_ready, opcode, lookup_key,    | get or put, one transfer
//          | write_value                               | per request
// result   | out_valid/out_ready, hit, read_value,     | one transfer per request
//          | evicted, evicted_key                      |
// apb      | psel, penable, pwrite, paddr, pwdata,     | capacity_in_use at 0x0
//          | prdata, pready                            |
//
// each request passes through the engine steps (pop, lane compare, rank update with
// value memory access, result load); the engine sequencer sets the rate.
// a 2-entry queue lets requests be taken while the engine or the result waits.
// reset empties the cache at once (valid bits in flops), no clearing pass.
// a stalled result holds the engine in its last step; the queue keeps accepting until full.
`timescale 1ns / 1ps
module lru_key_value_cache_core import lcc_pkg::*; #(
	parameter int ENTRIES  = 16,
	parameter int KEY_BITS = 16
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      psel,
	input  logic                      penable,
	input  logic                      pwrite,
	input  logic [ADDR_W-1:0]         paddr,
	input  logic [PDATA_W-1:0]        pwdata,
	output logic [PDATA_W-1:0]        prdata,
	output logic                      pready,
	input  logic                      in_valid,
	output logic                      in_ready,
	input  logic                      opcode,
	input  logic [KEY_W-1:0]          lookup_key,
	input  logic signed [VALUE_W-1:0] write_value,
	output logic                      out_valid,
	input  logic                      out_ready,
	output logic                      hit,
	output logic signed [VALUE_W-1:0] read_value,
	output logic                      evicted,
	output logic [KEY_W-1:0]          evicted_key
);
	logic [CAP_W-1:0] cap_q;
	logic             cap_wr;
	cfg_t             cfg;
	logic             q_valid;
	req_t             q_req;
	logic             q_pop;

	// register write on the access phase
	assign pready = 1'b1;
	assign cap_wr = psel && penable && pwrite && (paddr[2] == REG_CAPACITY);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= CAP_RESET;
		end else if (cap_wr) begin
			cap_q <= pwdata[CAP_W-1:0];
		end
	end

	// register read
	assign prdata = (paddr[2] == REG_CAPACITY) ? PDATA_W'(cap_q) : '0;

	// new capacity goes to the engine together with the write strobe
	assign cfg.wr  = cap_wr;
	assign cfg.cap = cap_wr ? pwdata[CAP_W-1:0] : cap_q;

	lcc_front #(
		.KEY_BITS(KEY_BITS)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.opcode     (opcode),
		.lookup_key (lookup_key),
		.write_value(write_value),
		.q_valid    (q_valid),
		.q_req      (q_req),
		.q_pop      (q_pop)
	);

	lcc_engine #(
		.ENTRIES(ENTRIES)
	) u_engine (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg),
		.q_valid    (q_valid),
		.q_req      (q_req),
		.q_pop      (q_pop),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.hit        (hit),
		.read_value (read_value),
		.evicted    (evicted),
		.evicted_key(evicted_key)
	);
endmodule

/* design/lcc_front.sv */
// front end: accepts requests, classifies them and buffers them in a short queue
// depends on lcc_pkg
`timescale 1ns / 1ps
module lcc_front import lcc_pkg::*; #(
	parameter int KEY_BITS = 16
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_ready,
	input  logic                      opcode,
	input  logic [KEY_W-1:0]          lookup_key,
	input  logic signed [VALUE_W-1:0] write_value,
	output logic                      q_valid,
	output req_t                      q_req,
	input  logic                      q_pop
);
	localparam int PTR_W  = $clog2(QUEUE_DEPTH);
	localparam int FILL_W = $clog2(QUEUE_DEPTH + 1);

	req_t              mem_q [QUEUE_DEPTH];
	logic [PTR_W-1:0]  wr_ptr_q;
	logic [PTR_W-1:0]  rd_ptr_q;
	logic [FILL_W-1:0] fill_q;
	logic [KEY_W-1:0]  key_mask;
	req_t              req_in;
	logic              push;
	logic              pop;

	// key bits above KEY_BITS are ignored
	always_comb begin
		for (int i = 0; i < KEY_W; i++) begin
			key_mask[i] = (i < KEY_BITS);
		end
	end

	// classify the incoming transfer
	always_comb begin
		req_in.is_put = (opcode == OP_PUT);
		req_in.key    = lookup_key & key_mask;
		req_in.value  = write_value;
	end

	assign in_ready = (fill_q != FILL_W'(QUEUE_DEPTH));
	assign push     = in_valid && in_ready;
	assign q_valid  = (fill_q != '0);
	assign pop      = q_pop && q_valid;
	assign q_req    = mem_q[rd_ptr_q];

	// queue storage
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= req_in;
		end
	end

	// queue pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				fill_q <= fill_q + 1'b1;
			end else if (pop && !push) begin
				fill_q <= fill_q - 1'b1;
			end
		end
	end
endmodule

/* design/lcc_engine.sv */
// back end: key match lanes, recency ranks, value memory and result register
// depends on lcc_pkg and lru_key_value_cache_core_macros.svh
`timescale 1ns / 1ps
`include "lru_key_value_cache_core_macros.svh"
module lcc_engine import lcc_pkg::*; #(
	parameter int ENTRIES = 16
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  cfg_t                      cfg,
	input  logic                      q_valid,
	input  req_t                      q_req,
	output logic                      q_pop,
	output logic                      out_valid,
	input  logic                      out_ready,
	output logic                      hit,
	output logic signed [VALUE_W-1:0] read_value,
	output logic                      evicted,
	output logic [KEY_W-1:0]          evicted_key
);
	localparam int IDX_W = $clog2(ENTRIES);
	localparam int CNT_W = $clog2(ENTRIES + 1);

	typedef enum logic [1:0] {S_IDLE, S_MATCH, S_DECIDE, S_RESP} state_t;

	state_t             state_q;
	req_t               req_q;
	logic [KEY_W-1:0]   keys_q [ENTRIES];
	logic [IDX_W-1:0]   rank_q [ENTRIES];
	logic [ENTRIES-1:0] valid_q;
	logic [CNT_W-1:0]   count_q;
	logic [ENTRIES-1:0] match_q;
	logic [ENTRIES-1:0] lru_q;
	logic [ENTRIES-1:0] free_q;
	logic [VALUE_W-1:0] value_mem [ENTRIES];
	logic [VALUE_W-1:0] rdata_q;
	logic               res_hit_q;
	logic               res_evict_q;
	logic [KEY_W-1:0]   res_key_q;
	logic               out_valid_q;
	logic               hit_q;
	logic [VALUE_W-1:0] read_value_q;
	logic               evicted_q;
	logic [KEY_W-1:0]   evicted_key_q;

	logic [CNT_W-1:0]   cap_eff;
	logic [ENTRIES-1:0] match_d;
	logic [ENTRIES-1:0] lru_d;
	logic [ENTRIES-1:0] free_d;
	logic [ENTRIES-1:0] inv;
	logic               hit_d;
	logic               ins_d;
	logic               evict_d;
	logic               act_d;
	logic [ENTRIES-1:0] slot_oh;
	logic [IDX_W-1:0]   slot_idx;
	logic [IDX_W-1:0]   hit_rank;
	logic [KEY_W-1:0]   ev_key;
	logic               load_out;

	// effective capacity: zero reads as one, saturate at the entry count
	always_comb begin
		if (cfg.cap == '0) begin
			cap_eff = CNT_W'(1);
		end else if (int'(cfg.cap) > ENTRIES) begin
			cap_eff = CNT_W'(ENTRIES);
		end else begin
			cap_eff = CNT_W'(cfg.cap);
		end
	end

	// per-lane compare, lru lane (rank count-1) and lowest free lane
	always_comb begin
		for (int i = 0; i < ENTRIES; i++) begin
			match_d[i] = valid_q[i] && (keys_q[i] == req_q.key);
			lru_d[i]   = valid_q[i] && (CNT_W'(rank_q[i]) == count_q - 1'b1);
		end
		inv    = ~valid_q;
		free_d = inv & (~inv + 1'b1);
	end

	// decision on the registered lane vectors
	always_comb begin
		hit_d    = |match_q;
		ins_d    = !hit_d && req_q.is_put;
		evict_d  = ins_d && (count_q >= cap_eff);
		act_d    = hit_d || ins_d;
		slot_oh  = hit_d ? match_q : (evict_d ? lru_q : (ins_d ? free_q : '0));
		slot_idx = '0;
		hit_rank = '0;
		ev_key   = '0;
		for (int i = 0; i < ENTRIES; i++) begin
			slot_idx = slot_idx | (slot_oh[i] ? IDX_W'(i) : '0);
			hit_rank = hit_rank | (match_q[i] ? rank_q[i] : '0);
			ev_key   = ev_key | (lru_q[i] ? keys_q[i] : '0);
		end
	end

	assign q_pop    = (state_q == S_IDLE) && q_valid;
	assign load_out = (state_q == S_RESP) && (!out_valid_q || out_ready);

	// sequencer, lane vectors and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_IDLE;
			req_q         <= '0;
			match_q       <= '0;
			lru_q         <= '0;
			free_q        <= '0;
			res_hit_q     <= 1'b0;
			res_evict_q   <= 1'b0;
			res_key_q     <= '0;
			out_valid_q   <= 1'b0;
			hit_q         <= 1'b0;
			read_value_q  <= '0;
			evicted_q     <= 1'b0;
			evicted_key_q <= '0;
		end else begin
			// result valid: set on load, cleared on transfer
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (q_valid) begin
						req_q   <= q_req;
						state_q <= S_MATCH;
					end
				end
				S_MATCH: begin
					match_q <= match_d;
					lru_q   <= lru_d;
					free_q  <= free_d;
					state_q <= S_DECIDE;
				end
				S_DECIDE: begin
					res_hit_q   <= hit_d;
					res_evict_q <= evict_d;
					res_key_q   <= evict_d ? ev_key : '0;
					state_q     <= S_RESP;
				end
				S_RESP: begin
					if (load_out) begin
						hit_q         <= res_hit_q;
						read_value_q  <= (res_hit_q && !req_q.is_put) ? rdata_q : '0;
						evicted_q     <= res_evict_q;
						evicted_key_q <= res_key_q;
						state_q       <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// lane state: valid bits, ranks and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			count_q <= '0;
			for (int i = 0; i < ENTRIES; i++) begin
				rank_q[i] <= '0;
			end
		end else if (cfg.wr) begin
			// drop the entries ranked at or above the new capacity
			for (int i = 0; i < ENTRIES; i++) begin
				if (valid_q[i] && (CNT_W'(rank_q[i]) >= cap_eff)) begin
					valid_q[i] <= 1'b0;
					rank_q[i]  <= '0;
				end
			end
			if (count_q > cap_eff) begin
				count_q <= cap_eff;
			end
		end else if (state_q == S_DECIDE && act_d) begin
			for (int i = 0; i < ENTRIES; i++) begin
				if (slot_oh[i]) begin
					valid_q[i] <= 1'b1;
					rank_q[i]  <= '0;
				end else if (valid_q[i] && (ins_d || rank_q[i] < hit_rank)) begin
					rank_q[i] <= rank_q[i] + 1'b1;
				end
			end
			if (ins_d && !evict_d) begin
				count_q <= count_q + 1'b1;
			end
		end
	end

	// key lanes
	always_ff @(posedge clk) begin
		if (state_q == S_DECIDE && ins_d) begin
			for (int i = 0; i < ENTRIES; i++) begin
				if (slot_oh[i]) begin
					keys_q[i] <= req_q.key;
				end
			end
		end
	end

	// value memory: one registered read per request, plus a write on a put that hits or inserts
	always_ff @(posedge clk) begin
		if (state_q == S_DECIDE) begin
			if (req_q.is_put && act_d) begin
				value_mem[slot_idx] <= req_q.value;
			end
			rdata_q <= value_mem[slot_idx];
		end
	end

	assign out_valid   = out_valid_q;
	assign hit         = hit_q;
	assign read_value  = read_value_q;
	assign evicted     = evicted_q;
	assign evicted_key = evicted_key_q;

	// checks
	`LCC_ASSERT_ALWAYS(a_match_unique, $onehot0(match_q))
	`LCC_ASSERT_ALWAYS(a_lru_unique, $onehot0(lru_q))
	`LCC_ASSERT_ALWAYS(a_count_tracks, count_q == CNT_W'($countones(valid_q)))
	`LCC_ASSERT_IMPLY(a_evict_full, (state_q == S_DECIDE) && evict_d, |lru_q)
	`LCC_ASSERT_NEXT(a_put_occupies, (state_q == S_DECIDE) && req_q.is_put && !cfg.wr,
		count_q != '0)
endmodule

/* dv/lru_key_value_cache_core_tb.sv */
// self-checking testbench for lru_key_value_cache_core: random and directed get/put traffic
// depends on lcc_pkg and lru_key_value_cache_core; carries its own lru predictor
`timescale 1ns / 1ps
module lru_key_value_cache_core_tb;
	import lcc_pkg::*;

	localparam int ENTRIES           = 16;
	localparam int RAND_PHASES       = 12;
	localparam int REQS_PER_PHASE    = 125;
	localparam int LONG_STALL_AT     = 1200;
	localparam int LONG_STALL_CYCLES = 250;
	localparam int MAX_REPORTS       = 10;
	localparam logic [ADDR_W-1:0] CAP_ADDR = ADDR_W'({REG_CAPACITY, 2'b00});

	typedef struct packed {
		logic               op;
		logic [KEY_W-1:0]   key;
		logic [VALUE_W-1:0] value;
	} cache_req_t;

	typedef struct packed {
		logic               hit;
		logic [VALUE_W-1:0] read_value;
		logic               evicted;
		logic [KEY_W-1:0]   evicted_key;
	} cache_result_t;

	logic                      clk         = 1'b0;
	logic                      arst_n      = 1'b0;
	logic                      psel        = 1'b0;
	logic                      penable     = 1'b0;
	logic                      pwrite      = 1'b0;
	logic [ADDR_W-1:0]         paddr       = '0;
	logic [PDATA_W-1:0]        pwdata      = '0;
	logic [PDATA_W-1:0]        prdata;
	logic                      pready;
	logic                      in_valid    = 1'b0;
	logic                      in_ready;
	logic                      opcode      = OP_GET;
	logic [KEY_W-1:0]          lookup_key  = '0;
	logic signed [VALUE_W-1:0] write_value = '0;
	logic                      out_valid;
	logic                      out_ready   = 1'b0;
	logic                      hit;
	logic signed [VALUE_W-1:0] read_value;
	logic                      evicted;
	logic [KEY_W-1:0]          evicted_key;

	lru_key_value_cache_core i_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.psel       (psel),
		.penable    (penable),
		.pwrite     (pwrite),
		.paddr      (paddr),
		.pwdata     (pwdata),
		.prdata     (prdata),
		.pready     (pready),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.opcode     (opcode),
		.lookup_key (lookup_key),
		.write_value(write_value),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.hit        (hit),
		.read_value (read_value),
		.evicted    (evicted),
		.evicted_key(evicted_key)
	);

	// predictor state: mirror of the cache contents and the capacity register
	logic [KEY_W-1:0]   cache_key   [ENTRIES];
	logic [VALUE_W-1:0] cache_value [ENTRIES];
	bit                 cache_valid [ENTRIES];
	int unsigned        cache_rank  [ENTRIES];
	logic [CAP_W-1:0]   cache_capacity = CAP_RESET;

	cache_req_t    pending_reqs[$];
	cache_result_t expected_results[$];
	cache_req_t    offered_req;
	cache_result_t want_result;
	cache_result_t got_result;

	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	int mismatches    = 0;
	int n_accepted    = 0;
	int n_results     = 0;
	int n_hits        = 0;
	int n_evictions   = 0;
	int n_cap_writes  = 0;
	int stall_left    = 0;
	bit long_stall_done = 1'b0;

	// capacity as the cache applies it: zero acts as one, large values saturate
	function automatic int unsigned usable_capacity();
		if (cache_capacity == 0)
			return 1;
		if (cache_capacity > ENTRIES)
			return ENTRIES;
		return cache_capacity;
	endfunction

	// move a slot to most recent; valid entries younger than old_rank age by one
	function automatic void make_most_recent(input int slot, input int unsigned old_rank);
		for (int i = 0; i < ENTRIES; i++) begin
			if (i != slot && cache_valid[i] && cache_rank[i] < old_rank)
				cache_rank[i]++;
		end
		cache_rank[slot] = 0;
	endfunction

	// apply one get or put to the mirror and return the result it should produce
	function automatic cache_result_t lru_access(input cache_req_t r);
		cache_result_t res = '0;
		int            hit_slot  = -1;
		int            free_slot = -1;
		int            lru_slot  = -1;
		int            slot;
		int unsigned   lru_rank  = 0;
		int unsigned   count     = 0;
		int unsigned   cap;
		cap = usable_capacity();
		for (int i = 0; i < ENTRIES; i++) begin
			if (cache_valid[i]) begin
				count++;
				if (cache_key[i] == r.key && hit_slot < 0)
					hit_slot = i;
				if (lru_slot < 0 || cache_rank[i] > lru_rank) begin
					lru_slot = i;
					lru_rank = cache_rank[i];
				end
			end else if (free_slot < 0) begin
				free_slot = i;
			end
		end
		if (hit_slot >= 0) begin
			res.hit = 1'b1;
			if (r.op == OP_PUT)
				cache_value[hit_slot] = r.value;
			else
				res.read_value = cache_value[hit_slot];
			make_most_recent(hit_slot, cache_rank[hit_slot]);
		end else if (r.op == OP_PUT) begin
			slot = free_slot;
			if (count >= cap && lru_slot >= 0) begin
				res.evicted     = 1'b1;
				res.evicted_key = cache_key[lru_slot];
				slot            = lru_slot;
				cache_valid[slot] = 1'b0;
			end
			if (slot >= 0) begin
				cache_key[slot]   = r.key;
				cache_value[slot] = r.value;
				cache_valid[slot] = 1'b1;
				make_most_recent(slot, ENTRIES);
			end
		end
		return res;
	endfunction

	// clock
	initial begin
		forever #4 clk = ~clk;
	end

	// request driver: offers queued requests, predicts each one as it transfers
	always @(posedge clk) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			if (in_valid && in_ready) begin
				expected_results.push_back(lru_access(offered_req));
				n_accepted++;
			end
			if (!in_valid || in_ready) begin
				if (pending_reqs.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					offered_req = pending_reqs.pop_front();
					in_valid    <= 1'b1;
					opcode      <= offered_req.op;
					lookup_key  <= offered_req.key;
					write_value <= offered_req.value;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// result monitor: checks each transfer against the oldest prediction, drives ready
	always @(posedge clk) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			if (out_valid && out_ready) begin
				got_result = '{hit, read_value, evicted, evicted_key};
				if (expected_results.size() == 0) begin
					mismatches++;
					if (mismatches <= MAX_REPORTS)
						$display("result %0d arrived with no request outstanding", n_results);
				end else begin
					want_result = expected_results.pop_front();
					if (got_result.hit !== want_result.hit
							|| got_result.read_value !== want_result.read_value
							|| got_result.evicted !== want_result.evicted
							|| got_result.evicted_key !== want_result.evicted_key) begin
						mismatches++;
						if (mismatches <= MAX_REPORTS) begin
							$write("result %0d: expected hit=%0b value=%h evict=%0b key=%h",
								n_results, want_result.hit, want_result.read_value,
								want_result.evicted, want_result.evicted_key);
							$display(", got hit=%0b value=%h evict=%0b key=%h",
								got_result.hit, got_result.read_value,
								got_result.evicted, got_result.evicted_key);
						end
					end
				end
				n_hits      += got_result.hit;
				n_evictions += got_result.evicted;
				n_results++;
			end
			// one long hold-off so the request queue fills and backs up
			if (stall_left != 0) begin
				stall_left--;
				out_ready <= 1'b0;
			end else if (!long_stall_done && n_results >= LONG_STALL_AT) begin
				long_stall_done = 1'b1;
				stall_left      = LONG_STALL_CYCLES;
				out_ready <= 1'b0;
			end else begin
				out_ready <= ($urandom_range(99) >= recv_idle_pct);
			end
		end
	end

	// one apb transfer to the capacity register
	task automatic apb_transfer(input logic is_write, input logic [PDATA_W-1:0] wdata,
			output logic [PDATA_W-1:0] rdata);
		@(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= is_write;
		paddr   <= CAP_ADDR;
		pwdata  <= wdata;
		@(posedge clk);
		penable <= 1'b1;
		@(negedge clk);
		rdata = prdata;
		if (pready !== 1'b1) begin
			mismatches++;
			if (mismatches <= MAX_REPORTS)
				$display("apb access phase: expected pready 1, got %b", pready);
		end
		@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
	endtask

	// write capacity, drop entries beyond it in the mirror, read it back
	task automatic program_capacity(input logic [CAP_W-1:0] cap_val);
		logic [PDATA_W-1:0] wdata;
		logic [PDATA_W-1:0] rdata;
		int unsigned        cap;
		wdata = PDATA_W'({$urandom, cap_val});
		apb_transfer(1'b1, wdata, rdata);
		cache_capacity = cap_val;
		cap = usable_capacity();
		for (int i = 0; i < ENTRIES; i++) begin
			if (cache_valid[i] && cache_rank[i] >= cap) begin
				cache_valid[i] = 1'b0;
				cache_rank[i]  = 0;
			end
		end
		n_cap_writes++;
		apb_transfer(1'b0, '0, rdata);
		if (rdata !== PDATA_W'(cap_val)) begin
			mismatches++;
			if (mismatches <= MAX_REPORTS)
				$display("capacity readback: expected %h, got %h", PDATA_W'(cap_val), rdata);
		end
	endtask

	task automatic queue_req(input logic op, input logic [KEY_W-1:0] key,
			input logic [VALUE_W-1:0] value);
		pending_reqs.push_back('{op, key, value});
	endtask

	// hold off new requests until every result is back
	task automatic wait_for_drain();
		while (pending_reqs.size() != 0 || in_valid || expected_results.size() != 0)
			@(negedge clk);
		repeat (6) @(negedge clk);
	endtask

	// stimulus
	initial begin
		logic [KEY_W-1:0]   key_pool[$];
		logic [KEY_W-1:0]   key;
		logic [VALUE_W-1:0] value;
		logic [CAP_W-1:0]   cap_plan[RAND_PHASES];
		int                 pick;

		for (int i = 0; i < ENTRIES; i++) begin
			cache_key[i]   = '0;
			cache_value[i] = '0;
			cache_valid[i] = 1'b0;
			cache_rank[i]  = 0;
		end
		cap_plan = '{5'd16, 5'd1, 5'd31, 5'd4, 5'd17, 5'd0, 5'd9, 5'd16, 5'd2,
			5'd7, 5'd31, 5'd5};
		cap_plan[9] = CAP_W'($urandom_range(31));

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		send_idle_pct = 7;
		recv_idle_pct = 78;

		// empty cache, key and value extremes, update of a present key
		queue_req(OP_GET, 16'h0000, 32'h0000_0000);
		queue_req(OP_PUT, 16'h0000, 32'h7fff_ffff);
		queue_req(OP_PUT, 16'hffff, 32'h8000_0000);
		queue_req(OP_GET, 16'hffff, 32'hffff_ffff);
		queue_req(OP_GET, 16'h0000, 32'h1234_5678);
		queue_req(OP_PUT, 16'h0000, 32'hffff_ffff);
		queue_req(OP_GET, 16'h0000, 32'h0000_0000);
		queue_req(OP_GET, 16'h1234, 32'h0000_0000);
		queue_req(OP_PUT, 16'ha5a5, 32'h5a5a_5a5a);
		queue_req(OP_PUT, 16'h5a5a, 32'ha5a5_a5a5);
		wait_for_drain();

		// shrink below occupancy, then evict out of a small cache
		program_capacity(5'd2);
		queue_req(OP_GET, 16'h0000, 32'h0000_0000);
		queue_req(OP_GET, 16'hffff, 32'h0000_0000);
		queue_req(OP_GET, 16'ha5a5, 32'h0000_0000);
		queue_req(OP_PUT, 16'h1111, 32'h0000_0001);
		queue_req(OP_PUT, 16'h2222, 32'h0000_0002);
		queue_req(OP_PUT, 16'h1111, 32'h0000_0003);
		queue_req(OP_PUT, 16'h3333, 32'h0000_0004);
		wait_for_drain();

		// zero capacity behaves as one entry
		program_capacity(5'd0);
		queue_req(OP_PUT, 16'h4444, 32'hdead_beef);
		queue_req(OP_GET, 16'h4444, 32'h0000_0000);
		queue_req(OP_PUT, 16'h4444, 32'h0bad_f00d);
		queue_req(OP_GET, 16'h3333, 32'h0000_0000);
		queue_req(OP_PUT, 16'h5555, 32'h0000_0000);
		wait_for_drain();

		// random phases over a spread of capacities, keys mostly from a small pool
		for (int ph = 0; ph < RAND_PHASES; ph++) begin
			if (ph < 4) begin
				send_idle_pct = 7;
				recv_idle_pct = 78;
			end else if (ph < 8) begin
				send_idle_pct = 78;
				recv_idle_pct = 7;
			end else begin
				send_idle_pct = 0;
				recv_idle_pct = 0;
			end
			program_capacity(cap_plan[ph]);
			key_pool.delete();
			for (int k = 0; k < usable_capacity() + 3; k++)
				key_pool.push_back(KEY_W'($urandom));
			for (int n = 0; n < REQS_PER_PHASE; n++) begin
				pick = $urandom_range(99);
				if (pick < 85)
					key = key_pool[$urandom_range(key_pool.size() - 1)];
				else if (pick < 88)
					key = '0;
				else if (pick < 91)
					key = '1;
				else
					key = KEY_W'($urandom);
				pick = $urandom_range(15);
				if (pick == 0)
					value = 32'h8000_0000;
				else if (pick == 1)
					value = 32'h7fff_ffff;
				else if (pick == 2)
					value = '0;
				else
					value = $urandom;
				queue_req(($urandom_range(99) < 45) ? OP_PUT : OP_GET, key, value);
			end
			wait_for_drain();
		end

		repeat (16) @(posedge clk);
		$display("ran %0d requests through %0d capacity writes", n_accepted, n_cap_writes);
		$display("saw %0d hits and %0d evictions, %0d mismatches", n_hits, n_evictions, mismatches);
		if (mismatches == 0 && expected_results.size() == 0) begin
			$display("lru_key_value_cache_core: match");
		end else begin
			$display("lru_key_value_cache_core: mismatch");
		end
		$finish;
	end

	// run limit
	initial begin
		#4_000_000;
		$display("lru_key_value_cache_core: mismatch");
		$finish;
	end
endmodule

/* lru_key_value_cache_core.f */
+incdir+design
design/lcc_pkg.sv
design/lcc_front.sv
design/lcc_engine.sv
design/lru_key_value_cache_core.sv
dv/lru_key_value_cache_core_tb.sv
